// ===== src/smlg_pkg.sv =====
// ----------------------------------------------------------------------------
// smlg_pkg: shared types and constants for the sorted list merge block
// Word formats on both channels, command codes and the queue entry format.
// ----------------------------------------------------------------------------
`default_nettype none

package smlg_pkg;

  localparam int DATA_W = 32;

  // Command codes as they arrive on the input channel.
  localparam logic [1:0] CMD_PUSH_FIRST  = 2'd0;
  localparam logic [1:0] CMD_PUSH_SECOND = 2'd1;
  localparam logic [1:0] CMD_MERGE       = 2'd2;

  // Depth of the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic        [1:0]        cmd;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] merged_value;
    logic                     last;
    logic                     overflowed;
  } out_word_t;

  // Operations after decoding; unused command codes never reach the queue.
  typedef enum logic [1:0] {
    OP_PUSH_FIRST,
    OP_PUSH_SECOND,
    OP_MERGE
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
  } q_entry_t;

endpackage

`default_nettype wire

// ===== src/sorted_list_merge.sv =====
// ----------------------------------------------------------------------------
// sorted_list_merge: stable two-way merge of two signed lists
// Top level: command queue front end and the list storage and merge engine.
// ----------------------------------------------------------------------------
// Each accepted word with a used command code goes into a four-word command
// queue, so the input keeps flowing while a merge is being emitted. The back
// end takes one command at a time; a merge emits one result word per cycle
// for N stored values while the output is not stalled, limited by the single
// read port of each list memory and the one output register. A merge with
// both lists empty emits nothing. Unused command codes are accepted and
// dropped. There is no clearing pass after reset; only list memory words
// below the fill counts are used.
`default_nettype none

module sorted_list_merge
  import smlg_pkg::*;
#(
  parameter int LIST_DEPTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_word_t     out_word
);

  logic     q_valid;
  logic     q_pop;
  q_entry_t q_entry;

  smlg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  smlg_back #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ===== src/smlg_front.sv =====
// ----------------------------------------------------------------------------
// smlg_front: command decode and queue
// Accepts input words, drops unused command codes and queues the rest for
// the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module smlg_front
  import smlg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  output logic          q_valid,
  output q_entry_t      q_entry,
  input  wire logic     q_pop
);

  q_entry_t            q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     fill_r, fill_nxt;
  logic                dec_ok;
  op_t                 dec_op;
  logic                q_push;
  logic                q_take;

  // Classify the incoming command; an unused code is accepted and dropped.
  always_comb begin
    dec_ok = 1'b1;
    dec_op = OP_MERGE;
    unique case (in_word.cmd)
      CMD_PUSH_FIRST:  dec_op = OP_PUSH_FIRST;
      CMD_PUSH_SECOND: dec_op = OP_PUSH_SECOND;
      CMD_MERGE:       dec_op = OP_MERGE;
      default:         dec_ok = 1'b0;
    endcase
  end

  assign in_stall = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid  = (fill_r != '0);
  assign q_entry  = q_mem_r[rd_ptr_r];
  assign q_push   = in_valid && !in_stall && dec_ok;
  assign q_take   = q_pop && q_valid;

  // Queue pointer and fill level update.
  always_comb begin
    wr_ptr_nxt = q_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_take ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r + (QPTR_W+1)'(q_push) - (QPTR_W+1)'(q_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem_r[wr_ptr_r] <= '{op: dec_op, value: in_word.value};
    end
  end

endmodule

`default_nettype wire

// ===== src/smlg_back.sv =====
// ----------------------------------------------------------------------------
// smlg_back: list storage and merge engine
// Executes queued pushes into the two list memories and runs the stable
// two-way merge into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smlg_back
  import smlg_pkg::*;
#(
  parameter int LIST_DEPTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  input  wire q_entry_t q_entry,
  output logic          q_pop,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_word_t     out_word
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int REM_W = CNT_W + 1;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  logic [DATA_W-1:0]        first_mem  [LIST_DEPTH];
  logic [DATA_W-1:0]        second_mem [LIST_DEPTH];
  logic signed [DATA_W-1:0] head_first_r, head_second_r;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] first_cnt_r, first_cnt_nxt;
  logic [CNT_W-1:0] second_cnt_r, second_cnt_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic             flag_r, flag_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  logic             out_ready;
  logic             take_first;
  logic             fire;
  logic             wr_first;
  logic             wr_second;

  assign out_ready = !out_valid_r || !out_stall;

  // Head-to-head pick: the first list wins ties, an exhausted list never wins.
  assign take_first = (i_r < first_cnt_r) &&
                      ((j_r >= second_cnt_r) || (head_first_r <= head_second_r));

  always_comb begin
    state_nxt      = state_r;
    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    rem_nxt        = rem_r;
    flag_nxt       = flag_r;
    out_word_nxt   = out_word_r;
    q_pop          = 1'b0;
    wr_first       = 1'b0;
    wr_second      = 1'b0;
    fire           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_entry.op)
            OP_PUSH_FIRST: begin
              if (first_cnt_r == CNT_W'(LIST_DEPTH)) begin
                flag_nxt = 1'b1;
              end else begin
                wr_first      = 1'b1;
                first_cnt_nxt = first_cnt_r + 1'b1;
              end
            end
            OP_PUSH_SECOND: begin
              if (second_cnt_r == CNT_W'(LIST_DEPTH)) begin
                flag_nxt = 1'b1;
              end else begin
                wr_second      = 1'b1;
                second_cnt_nxt = second_cnt_r + 1'b1;
              end
            end
            OP_MERGE: begin
              if (first_cnt_r == '0 && second_cnt_r == '0) begin
                flag_nxt = 1'b0;
              end else begin
                rem_nxt   = REM_W'(first_cnt_r) + REM_W'(second_cnt_r);
                state_nxt = S_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        if (out_ready) begin
          fire                      = 1'b1;
          out_word_nxt.merged_value = take_first ? head_first_r : head_second_r;
          out_word_nxt.last         = (rem_r == REM_W'(1));
          out_word_nxt.overflowed   = flag_r;
          if (take_first) begin
            i_nxt = i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
          rem_nxt = rem_r - 1'b1;
          // The final word clears both lists and the overflow flag.
          if (rem_r == REM_W'(1)) begin
            state_nxt      = S_IDLE;
            first_cnt_nxt  = '0;
            second_cnt_nxt = '0;
            i_nxt          = '0;
            j_nxt          = '0;
            flag_nxt       = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = fire || (out_valid_r && out_stall);
  end

  // State, counters and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      i_r          <= '0;
      j_r          <= '0;
      rem_r        <= '0;
      flag_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      first_cnt_r  <= first_cnt_nxt;
      second_cnt_r <= second_cnt_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      rem_r        <= rem_nxt;
      flag_r       <= flag_nxt;
      out_valid_r  <= out_valid_nxt;
      out_word_r   <= out_word_nxt;
    end
  end

  // List memories: one write port at the fill count, one registered read
  // port that follows the next merge index, so the heads are ready each cycle.
  always_ff @(posedge clk) begin
    if (wr_first) begin
      first_mem[first_cnt_r[IDX_W-1:0]] <= q_entry.value;
    end
    head_first_r <= first_mem[i_nxt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_second) begin
      second_mem[second_cnt_r[IDX_W-1:0]] <= q_entry.value;
    end
    head_second_r <= second_mem[j_nxt[IDX_W-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// ===== src/smlg_checker.sv =====
// ----------------------------------------------------------------------------
// smlg_checker: port-level checks for sorted_list_merge
// Watches the top-level ports and is attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module smlg_checker
  import smlg_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_word_t  in_word,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_word
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // Reset leaves no result word pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Within one run the overflow flag does not change.
  a_flag_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_word.last) ##1 out_valid
      |-> out_word.overflowed == $past(out_word.overflowed))
    else $error("overflow flag changed within a run");

  // A stalled input word holds until the block takes it.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("input word changed while stalled");

endmodule

bind sorted_list_merge smlg_checker u_smlg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire
